[design/i2cm_pkg.sv]
package i2cm_pkg;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_PTR_W     = 1;
  localparam logic [7:0]  DEV_ADDR_RST = 8'd174;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_READ_BYTE = 2'd1,
    OP_READ_WORD = 2'd2,
    OP_BURST     = 2'd3
  } op_t;

  typedef enum logic [15:0] {
    PH_IDLE = 16'b0000_0000_0000_0001,
    PH_ST_A = 16'b0000_0000_0000_0010,
    PH_ST_B = 16'b0000_0000_0000_0100,
    PH_TX_L = 16'b0000_0000_0000_1000,
    PH_TX_H = 16'b0000_0000_0001_0000,
    PH_TA_L = 16'b0000_0000_0010_0000,
    PH_TA_H = 16'b0000_0000_0100_0000,
    PH_RS_A = 16'b0000_0000_1000_0000,
    PH_RS_B = 16'b0000_0001_0000_0000,
    PH_RS_C = 16'b0000_0010_0000_0000,
    PH_RX_L = 16'b0000_0100_0000_0000,
    PH_RX_H = 16'b0000_1000_0000_0000,
    PH_MA_L = 16'b0001_0000_0000_0000,
    PH_MA_H = 16'b0010_0000_0000_0000,
    PH_SP_A = 16'b0100_0000_0000_0000,
    PH_SP_B = 16'b1000_0000_0000_0000
  } phase_t;

  // classified input word
  typedef struct packed {
    logic       is_tick;
    op_t        op;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // result word, declared MSB first so that scl_level lands in bit 0
  typedef struct packed {
    logic       status;
    logic       done_res;
    logic       busy_res;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       sda_is_input;
    logic       sda_level;
    logic       scl_level;
  } res_t;

endpackage

[design/i2c_master_register_access.sv]
// channel | dir | handshake            | payload
// in      | in  | in_tvalid/in_tready   | tuser: req_type (1 = tick)
//         |     |                       | tdata: op, reg_addr, write_data, sda_in
// out     | out | out_tvalid/out_tready | tdata: scl, sda, sda_is_input, rx_valid,
//         |     |                       |        rx_byte, busy, done, status
// cfg     | in  | cfg_tvalid/cfg_tready | tdata: device_address
//
// One word per cycle sustained while out_tready is high; each result appears in the cycle
// after its word leaves the 2-entry queue; input words pass the queue and then the result register.
// The bus state machine takes one step per popped word.
// Reset: synchronous active low; device_address returns to 0xAE, bus idle.
// The queue absorbs input while out_tready is low; in_tready drops when full.
module i2c_master_register_access
  import i2cm_pkg::*;
#(
  parameter int unsigned MAX_BURST = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // op[1:0], reg_addr[9:2], write_data[17:10],
                                             // sda_in[18], zero[23:19]
  input  logic                   in_tuser,   // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // scl_level[0], sda_level[1], sda_is_input[2],
                                             // rx_valid[3], rx_byte[11:4], busy_res[12],
                                             // done_res[13], status[14], zero[15]
  input  logic                   cfg_tvalid,
  output logic                   cfg_tready,
  input  logic [7:0]             cfg_tdata   // device_address
);

  logic       q_full, q_push, q_pop, q_not_empty;
  item_t      push_item, pop_item;
  res_t       res;
  logic [7:0] dev_addr_r;

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_tvalid) begin
      dev_addr_r <= cfg_tdata;
    end
  end

  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  i2cm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  i2cm_engine #(
    .MAX_BURST (MAX_BURST)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .dev_addr    (dev_addr_r),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  assign out_tdata = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, res};

endmodule

[design/i2cm_front.sv]
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // tuser: 1 = bus tick, 0 = command; command fields only matter for commands,
  // sampled SDA only for ticks
  always_comb begin
    q_item.is_tick    = in_tuser;
    q_item.op         = op_t'(in_tdata[1:0]);
    q_item.reg_addr   = in_tuser ? 8'd0 : in_tdata[9:2];
    q_item.write_data = in_tuser ? 8'd0 : in_tdata[17:10];
    q_item.sda_in     = in_tuser ? in_tdata[18] : 1'b0;
  end

endmodule

[design/i2cm_queue.sv]
module i2cm_queue
  import i2cm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count lost a push");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_PTR_W+1)'(Q_DEPTH))
    else $error("queue count overflow");

endmodule

[design/i2cm_engine.sv]
module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int unsigned MAX_BURST = 6
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] dev_addr,
  input  logic       q_not_empty,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  // byte index must reach 2 for the write path and MAX_BURST-1 for bursts
  localparam int unsigned BCW = (MAX_BURST > 4) ? $clog2(MAX_BURST) : 2;

  phase_t         phase_r, phase_nxt;
  logic [2:0]     bit_cnt_r, bit_cnt_nxt;
  logic [BCW-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [7:0]     shift_r, shift_nxt;
  op_t            op_r, op_nxt;
  logic [7:0]     reg_r, reg_nxt;
  logic [7:0]     data_r, data_nxt;
  logic           nack_r, nack_nxt;

  logic           out_valid_r;
  res_t           out_res_r, res_nxt;

  logic           rxv, done, last_cur, last_nxt;

  function automatic logic [BCW-1:0] last_idx(input op_t op);
    case (op)
      OP_READ_BYTE: last_idx = BCW'(0);
      OP_READ_WORD: last_idx = BCW'(1);
      default:      last_idx = BCW'(MAX_BURST - 1);
    endcase
  endfunction

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign last_cur  = (byte_cnt_r >= last_idx(op_r));

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    op_nxt       = op_r;
    reg_nxt      = reg_r;
    data_nxt     = data_r;
    nack_nxt     = nack_r;
    rxv          = 1'b0;
    done         = 1'b0;

    if (!q_item.is_tick) begin
      // a command while busy leaves the transaction alone
      if (phase_r == PH_IDLE) begin
        op_nxt       = q_item.op;
        reg_nxt      = q_item.reg_addr;
        data_nxt     = q_item.write_data;
        nack_nxt     = 1'b0;
        bit_cnt_nxt  = '0;
        byte_cnt_nxt = '0;
        phase_nxt    = PH_ST_A;
      end
    end else begin
      case (phase_r)
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_ST_A: phase_nxt = PH_ST_B;
        PH_ST_B: begin
          shift_nxt    = dev_addr;
          byte_cnt_nxt = BCW'(0);
          bit_cnt_nxt  = '0;
          phase_nxt    = PH_TX_L;
        end
        PH_TX_L: phase_nxt = PH_TX_H;
        PH_TX_H: begin
          if (bit_cnt_r == 3'd7) begin
            phase_nxt = PH_TA_L;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            phase_nxt   = PH_TX_L;
          end
        end
        PH_TA_L: phase_nxt = PH_TA_H;
        PH_TA_H: begin
          if (q_item.sda_in) begin
            nack_nxt  = 1'b1;
            phase_nxt = PH_SP_A;
          end else if (byte_cnt_r == BCW'(0)) begin
            shift_nxt    = reg_r;
            byte_cnt_nxt = BCW'(1);
            bit_cnt_nxt  = '0;
            phase_nxt    = PH_TX_L;
          end else if (byte_cnt_r == BCW'(1)) begin
            if (op_r == OP_WRITE) begin
              shift_nxt    = data_r;
              byte_cnt_nxt = BCW'(2);
              bit_cnt_nxt  = '0;
              phase_nxt    = PH_TX_L;
            end else begin
              phase_nxt = PH_RS_A;
            end
          end else if (op_r == OP_WRITE) begin
            phase_nxt = PH_SP_A;
          end else begin
            byte_cnt_nxt = '0;
            bit_cnt_nxt  = '0;
            shift_nxt    = '0;
            phase_nxt    = PH_RX_L;
          end
        end
        PH_RS_A: phase_nxt = PH_RS_B;
        PH_RS_B: phase_nxt = PH_RS_C;
        PH_RS_C: begin
          shift_nxt    = dev_addr + 8'd1;
          byte_cnt_nxt = BCW'(2);
          bit_cnt_nxt  = '0;
          phase_nxt    = PH_TX_L;
        end
        PH_RX_L: phase_nxt = PH_RX_H;
        PH_RX_H: begin
          shift_nxt = {shift_r[6:0], q_item.sda_in};
          if (bit_cnt_r == 3'd7) begin
            rxv       = 1'b1;
            phase_nxt = PH_MA_L;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            phase_nxt   = PH_RX_L;
          end
        end
        PH_MA_L: phase_nxt = PH_MA_H;
        PH_MA_H: begin
          if (last_cur) begin
            phase_nxt = PH_SP_A;
          end else begin
            byte_cnt_nxt = byte_cnt_r + 1'b1;
            bit_cnt_nxt  = '0;
            shift_nxt    = '0;
            phase_nxt    = PH_RX_L;
          end
        end
        PH_SP_A: phase_nxt = PH_SP_B;
        PH_SP_B: begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // pin drive follows the updated state
  assign last_nxt = (byte_cnt_nxt >= last_idx(op_nxt));

  always_comb begin
    res_nxt              = '0;
    res_nxt.scl_level    = 1'b1;
    res_nxt.sda_level    = 1'b1;
    res_nxt.rx_valid     = rxv;
    res_nxt.rx_byte      = rxv ? shift_nxt : 8'd0;
    res_nxt.busy_res     = (phase_nxt != PH_IDLE);
    res_nxt.done_res     = done;
    res_nxt.status       = done && nack_nxt;
    case (phase_nxt)
      PH_ST_B: res_nxt.sda_level = 1'b0;
      PH_TX_L: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_level = shift_nxt[3'd7 - bit_cnt_nxt];
      end
      PH_TX_H: res_nxt.sda_level = shift_nxt[3'd7 - bit_cnt_nxt];
      PH_TA_L, PH_RX_L: begin
        res_nxt.scl_level    = 1'b0;
        res_nxt.sda_is_input = 1'b1;
      end
      PH_TA_H, PH_RX_H: res_nxt.sda_is_input = 1'b1;
      PH_RS_A: res_nxt.scl_level = 1'b0;
      PH_RS_C: res_nxt.sda_level = 1'b0;
      PH_MA_L: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_level = last_nxt;
      end
      PH_MA_H: res_nxt.sda_level = last_nxt;
      PH_SP_A: begin
        res_nxt.scl_level = 1'b0;
        res_nxt.sda_level = 1'b0;
      end
      PH_SP_B: res_nxt.sda_level = 1'b0;
      default: res_nxt.sda_level = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      shift_r     <= '0;
      op_r        <= OP_WRITE;
      reg_r       <= '0;
      data_r      <= '0;
      nack_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        byte_cnt_r  <= byte_cnt_nxt;
        shift_r     <= shift_nxt;
        op_r        <= op_nxt;
        reg_r       <= reg_nxt;
        data_r      <= data_nxt;
        nack_r      <= nack_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= res_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_valid_r)
    else $error("popped word produced no result");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.busy_res == (phase_r != PH_IDLE)))
    else $error("busy flag disagrees with phase");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.rx_valid) |-> (phase_r == PH_MA_L))
    else $error("received byte outside master ack slot");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status) |-> (out_res_r.done_res && nack_r))
    else $error("nack status without stop");

endmodule
